### sv/celu_pkg.sv
// ----------------------------------------------------------------------------
// celu_pkg: shared types and constants for the CSR element lookup store
// Opcodes, status codes, sequencer states and the command structs that pass
// between the sequencer and the two storage blocks.
// ----------------------------------------------------------------------------
package celu_pkg;

  // Default sizing for the top level.
  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int VALUE_BITS_DEF  = 64;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int ROW_W    = 8;
  localparam int COL_W    = 8;
  localparam int LEN_W    = 9;
  localparam int DATA_W   = 64;
  localparam int STAT_W   = 2;

  // in_tdata layout: row, column, row_length, data_word; padded to bytes.
  localparam int IN_ROW_LSB  = 0;
  localparam int IN_COL_LSB  = IN_ROW_LSB + ROW_W;
  localparam int IN_LEN_LSB  = IN_COL_LSB + COL_W;
  localparam int IN_DATA_LSB = IN_LEN_LSB + LEN_W;
  localparam int IN_TDATA_W  = ((IN_DATA_LSB + DATA_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_APPEND = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_ROW  = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } state_t;

  // Sequencer -> row table
  typedef struct packed {
    logic load;
    logic rd;
  } row_cmd_t;

  // Row table -> sequencer
  typedef struct packed {
    logic load_ok;
    logic row_ok;
  } row_stat_t;

  // Sequencer -> entry store
  typedef struct packed {
    logic append;
    logic rd;
    logic wr;
  } ent_cmd_t;

endpackage

### sv/csr_element_lookup_store_unit.sv
// ----------------------------------------------------------------------------
// csr_element_lookup_store_unit: compressed-sparse-row element store
// Row lengths build start offsets by prefix sum, columns are appended in
// order, and reads/writes of (row, column) scan the row for a matching column.
// ----------------------------------------------------------------------------
// Sequence: load, append and out-of-range lookups go from accept to S_DONE
//   and then the output register; an in-range read or write passes S_ROW,
//   then the scan of the row, then S_DONE and the output register.
// Throughput: one transaction at a time; in_tready returns together with
//   out_tvalid. The row scan reads one stored column per cycle through the
//   entry memory read port.
// Reset: synchronous, active low; counters and handshake state clear,
//   memories are not swept (value slots are zeroed as columns append).
// ----------------------------------------------------------------------------
module csr_element_lookup_store_unit #(
  parameter int MAX_ROWS    = celu_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = celu_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = celu_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] row, [15:8] column, [24:16] row_length, [88:25] data_word, rest zero
  input  logic [celu_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] opcode
  input  logic [celu_pkg::OP_W-1:0]       in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] read_word
  output logic [celu_pkg::DATA_W-1:0]     out_tdata,
  // [1:0] status
  output logic [celu_pkg::STAT_W-1:0]     out_tuser
);

  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int EIW = $clog2(MAX_ENTRIES);

  // Input field split. data_word is cut to VALUE_BITS here.
  logic [celu_pkg::ROW_W-1:0] in_row;
  logic [celu_pkg::COL_W-1:0] in_col;
  logic [celu_pkg::LEN_W-1:0] in_len;
  logic [VALUE_BITS-1:0]      in_data;
  celu_pkg::opcode_t          in_op;

  assign in_row  = in_tdata[celu_pkg::IN_ROW_LSB +: celu_pkg::ROW_W];
  assign in_col  = in_tdata[celu_pkg::IN_COL_LSB +: celu_pkg::COL_W];
  assign in_len  = in_tdata[celu_pkg::IN_LEN_LSB +: celu_pkg::LEN_W];
  assign in_data = in_tdata[celu_pkg::IN_DATA_LSB +: VALUE_BITS];
  assign in_op   = celu_pkg::opcode_t'(in_tuser);

  celu_pkg::row_cmd_t  row_cmd;
  celu_pkg::row_stat_t row_stat;
  celu_pkg::ent_cmd_t  ent_cmd;

  logic [celu_pkg::LEN_W-1:0] row_len;
  logic [ECW-1:0]             row_base;
  logic [EIW-1:0]             ent_rd_addr, ent_wr_addr;
  logic [celu_pkg::COL_W-1:0] ent_wr_col, ent_rd_col;
  logic [VALUE_BITS-1:0]      ent_wr_value, ent_rd_value;
  logic                       ent_append_ok;
  logic [ECW-1:0]             ent_count;

  logic                       res_valid, res_ready;
  logic [VALUE_BITS-1:0]      res_word;
  celu_pkg::status_t          res_status;

  // Row descriptors: lengths, start offsets, loaded count, prefix sum.
  celu_row_table #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_row_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (row_cmd),
    .row        (in_row),
    .row_length (in_len),
    .stat       (row_stat),
    .rd_len     (row_len),
    .rd_base    (row_base)
  );

  // Column indices and value words, one entry per appended column.
  celu_entry_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_entry_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ent_cmd),
    .append_col (in_col),
    .rd_addr    (ent_rd_addr),
    .wr_addr    (ent_wr_addr),
    .wr_col     (ent_wr_col),
    .wr_value   (ent_wr_value),
    .append_ok  (ent_append_ok),
    .count      (ent_count),
    .rd_col     (ent_rd_col),
    .rd_value   (ent_rd_value)
  );

  // Sequencer. Only one transaction is in flight, so a memory write never
  // overlaps a read of the same entry and no forwarding is needed.
  celu_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_op         (in_op),
    .in_col        (in_col),
    .in_data       (in_data),
    .row_cmd       (row_cmd),
    .row_stat      (row_stat),
    .row_len       (row_len),
    .row_base      (row_base),
    .ent_cmd       (ent_cmd),
    .ent_rd_addr   (ent_rd_addr),
    .ent_wr_addr   (ent_wr_addr),
    .ent_wr_col    (ent_wr_col),
    .ent_wr_value  (ent_wr_value),
    .ent_append_ok (ent_append_ok),
    .ent_count     (ent_count),
    .ent_rd_col    (ent_rd_col),
    .ent_rd_value  (ent_rd_value),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_word      (res_word),
    .res_status    (res_status)
  );

  // Output register: frees the sequencer to take the next transaction while a
  // finished result is still waiting downstream.
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_word_r;
  celu_pkg::status_t     out_status_r;
  logic                  out_load;

  assign res_ready     = !out_valid_r || out_tready;
  assign out_load      = res_valid && res_ready;
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r   <= res_word;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = celu_pkg::DATA_W'(out_word_r);
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Anything other than a good lookup carries a zero word.
  a_word_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != celu_pkg::ST_OK)) |-> (out_tdata == '0))
    else $error("nonzero read_word with non-ok status");

  // The entry memory port never sees a scan read and a hit write together.
  a_ent_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ent_cmd.rd && ent_cmd.wr))
    else $error("entry store read and write in the same cycle");

  // A lookup in range holds off the next transaction while it scans.
  a_lookup_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && row_cmd.rd && row_stat.row_ok) |=> !in_tready)
    else $error("input taken during a row scan");

  // A loaded append or load never reaches the output as a miss.
  a_no_miss_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (row_cmd.load || ent_cmd.append))
      |=> (res_valid && (res_status != celu_pkg::ST_MISS)))
    else $error("load or append finished with miss status");

endmodule

### sv/celu_row_table.sv
// ----------------------------------------------------------------------------
// celu_row_table: row length and row start memory
// Holds one {length, start} word per loaded row, the loaded row count and the
// running prefix sum. Loads are range checked here; read data is registered.
// ----------------------------------------------------------------------------
module celu_row_table #(
  parameter int MAX_ROWS    = celu_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = celu_pkg::MAX_ENTRIES_DEF,
  localparam int ECW        = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  celu_pkg::row_cmd_t         cmd,
  input  logic [celu_pkg::ROW_W-1:0] row,
  input  logic [celu_pkg::LEN_W-1:0] row_length,
  output celu_pkg::row_stat_t        stat,
  output logic [celu_pkg::LEN_W-1:0] rd_len,
  output logic [ECW-1:0]             rd_base
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int MW  = celu_pkg::LEN_W + ECW;

  logic [MW-1:0]  row_mem [MAX_ROWS];
  logic [MW-1:0]  row_q_r;
  logic [RCW-1:0] rows_loaded_r, rows_loaded_nxt;
  logic [ECW-1:0] total_r, total_nxt;
  logic [31:0]    total_sum;
  logic           do_load;

  assign total_sum    = 32'(total_r) + 32'(row_length);
  assign stat.load_ok = (rows_loaded_r < RCW'(MAX_ROWS)) &&
                        (total_sum <= 32'(MAX_ENTRIES));
  assign stat.row_ok  = 32'(row) < 32'(rows_loaded_r);
  assign do_load      = cmd.load && stat.load_ok;

  assign rows_loaded_nxt = do_load ? rows_loaded_r + RCW'(1) : rows_loaded_r;
  assign total_nxt       = do_load ? ECW'(total_sum) : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_loaded_r <= '0;
      total_r       <= '0;
    end else begin
      rows_loaded_r <= rows_loaded_nxt;
      total_r       <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      row_mem[rows_loaded_r[RIW-1:0]] <= {row_length, total_r};
    end
    if (cmd.rd) begin
      row_q_r <= row_mem[RIW'(32'(row))];
    end
  end

  assign rd_len  = row_q_r[MW-1 -: celu_pkg::LEN_W];
  assign rd_base = row_q_r[ECW-1:0];

endmodule

### sv/celu_entry_store.sv
// ----------------------------------------------------------------------------
// celu_entry_store: column index and value word memory
// One {column, value} word per appended entry plus the fill count. An append
// writes its value slot to zero, so slots at or above the fill count never
// need clearing. One read and one write port; read data registered.
// ----------------------------------------------------------------------------
module celu_entry_store #(
  parameter int MAX_ENTRIES = celu_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = celu_pkg::VALUE_BITS_DEF,
  localparam int ECW        = $clog2(MAX_ENTRIES + 1),
  localparam int EIW        = $clog2(MAX_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  celu_pkg::ent_cmd_t         cmd,
  input  logic [celu_pkg::COL_W-1:0] append_col,
  input  logic [EIW-1:0]             rd_addr,
  input  logic [EIW-1:0]             wr_addr,
  input  logic [celu_pkg::COL_W-1:0] wr_col,
  input  logic [VALUE_BITS-1:0]      wr_value,
  output logic                       append_ok,
  output logic [ECW-1:0]             count,
  output logic [celu_pkg::COL_W-1:0] rd_col,
  output logic [VALUE_BITS-1:0]      rd_value
);

  localparam int MW = celu_pkg::COL_W + VALUE_BITS;

  logic [MW-1:0]  ent_mem [MAX_ENTRIES];
  logic [MW-1:0]  ent_q_r;
  logic [ECW-1:0] count_r, count_nxt;
  logic           do_append;

  assign append_ok = count_r < ECW'(MAX_ENTRIES);
  assign do_append = cmd.append && append_ok;
  assign count_nxt = do_append ? count_r + ECW'(1) : count_r;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Appends and hit writes never fall in the same cycle.
  always_ff @(posedge clk) begin
    if (do_append) begin
      ent_mem[count_r[EIW-1:0]] <= {append_col, {VALUE_BITS{1'b0}}};
    end else if (cmd.wr) begin
      ent_mem[wr_addr] <= {wr_col, wr_value};
    end
    if (cmd.rd) begin
      ent_q_r <= ent_mem[rd_addr];
    end
  end

  assign rd_col   = ent_q_r[MW-1 -: celu_pkg::COL_W];
  assign rd_value = ent_q_r[VALUE_BITS-1:0];

endmodule

### sv/celu_scan.sv
// ----------------------------------------------------------------------------
// celu_scan: transaction sequencer and row scan
// Takes one input transaction at a time, issues loads and appends, and for
// reads and writes to a loaded row fetches the row descriptor, then scans
// its columns one entry per cycle, comparing in the cycle after each read.
// ----------------------------------------------------------------------------
module celu_scan #(
  parameter int MAX_ENTRIES = celu_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = celu_pkg::VALUE_BITS_DEF,
  localparam int ECW        = $clog2(MAX_ENTRIES + 1),
  localparam int EIW        = $clog2(MAX_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input transaction
  input  logic                       in_valid,
  output logic                       in_ready,
  input  celu_pkg::opcode_t          in_op,
  input  logic [celu_pkg::COL_W-1:0] in_col,
  input  logic [VALUE_BITS-1:0]      in_data,
  // row table
  output celu_pkg::row_cmd_t         row_cmd,
  input  celu_pkg::row_stat_t        row_stat,
  input  logic [celu_pkg::LEN_W-1:0] row_len,
  input  logic [ECW-1:0]             row_base,
  // entry store
  output celu_pkg::ent_cmd_t         ent_cmd,
  output logic [EIW-1:0]             ent_rd_addr,
  output logic [EIW-1:0]             ent_wr_addr,
  output logic [celu_pkg::COL_W-1:0] ent_wr_col,
  output logic [VALUE_BITS-1:0]      ent_wr_value,
  input  logic                       ent_append_ok,
  input  logic [ECW-1:0]             ent_count,
  input  logic [celu_pkg::COL_W-1:0] ent_rd_col,
  input  logic [VALUE_BITS-1:0]      ent_rd_value,
  // result
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [VALUE_BITS-1:0]      res_word,
  output celu_pkg::status_t          res_status
);

  celu_pkg::state_t  state_r, state_nxt;
  celu_pkg::opcode_t op_r;
  celu_pkg::status_t status_r;
  logic [celu_pkg::COL_W-1:0] col_r;
  logic [VALUE_BITS-1:0]      data_r, word_r;
  logic [ECW-1:0]             ptr_r, limit_r, limit_nxt;
  logic [EIW-1:0]             chk_idx_r;
  logic                       chk_v_r, chk_v_nxt;
  logic                       accept, lookup, hit, at_end, issue;
  logic [31:0]                row_end, cnt_w;

  assign accept = in_valid && in_ready;
  assign lookup = (in_op == celu_pkg::OP_READ) || (in_op == celu_pkg::OP_WRITE);
  assign hit    = chk_v_r && (ent_rd_col == col_r);
  assign at_end = ptr_r >= limit_r;
  assign issue  = (state_r == celu_pkg::S_SCAN) && !hit && !at_end;

  // Scan stops at the row end or the fill count, whichever is first.
  assign row_end   = 32'(row_base) + 32'(row_len);
  assign cnt_w     = 32'(ent_count);
  assign limit_nxt = (row_end < cnt_w) ? ECW'(row_end) : ECW'(cnt_w);
  assign chk_v_nxt = issue;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      celu_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (lookup && row_stat.row_ok) ? celu_pkg::S_ROW : celu_pkg::S_DONE;
        end
      end
      celu_pkg::S_ROW: begin
        state_nxt = celu_pkg::S_SCAN;
      end
      celu_pkg::S_SCAN: begin
        if (hit || at_end) begin
          state_nxt = celu_pkg::S_DONE;
        end
      end
      celu_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = celu_pkg::S_IDLE;
        end
      end
      default: state_nxt = celu_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state_r == celu_pkg::S_IDLE);
    res_valid      = (state_r == celu_pkg::S_DONE);
    row_cmd.load   = accept && (in_op == celu_pkg::OP_LOAD);
    row_cmd.rd     = accept && lookup;
    ent_cmd.append = accept && (in_op == celu_pkg::OP_APPEND);
    ent_cmd.rd     = issue;
    ent_cmd.wr     = (state_r == celu_pkg::S_SCAN) && hit && (op_r == celu_pkg::OP_WRITE);
  end

  assign ent_rd_addr  = ptr_r[EIW-1:0];
  assign ent_wr_addr  = chk_idx_r;
  assign ent_wr_col   = col_r;
  assign ent_wr_value = data_r;
  assign res_word     = word_r;
  assign res_status   = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= celu_pkg::S_IDLE;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    case (state_r)
      celu_pkg::S_IDLE: begin
        if (accept) begin
          op_r   <= in_op;
          col_r  <= in_col;
          data_r <= in_data;
          word_r <= '0;
          case (in_op)
            celu_pkg::OP_LOAD:
              status_r <= row_stat.load_ok ? celu_pkg::ST_OK : celu_pkg::ST_RANGE;
            celu_pkg::OP_APPEND:
              status_r <= ent_append_ok ? celu_pkg::ST_OK : celu_pkg::ST_RANGE;
            default:
              status_r <= row_stat.row_ok ? celu_pkg::ST_OK : celu_pkg::ST_RANGE;
          endcase
        end
      end
      celu_pkg::S_ROW: begin
        ptr_r   <= row_base;
        limit_r <= limit_nxt;
      end
      celu_pkg::S_SCAN: begin
        if (hit) begin
          status_r <= celu_pkg::ST_OK;
          word_r   <= (op_r == celu_pkg::OP_READ) ? ent_rd_value : '0;
        end else if (at_end) begin
          status_r <= celu_pkg::ST_MISS;
          word_r   <= '0;
        end else begin
          chk_idx_r <= ptr_r[EIW-1:0];
          ptr_r     <= ptr_r + ECW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### tb/csr_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_lookup_checker: reply predictor and scoreboard for the CSR store
// Watches both stream channels. Every accepted command runs through a private
// model of the row table and entry store. Every accepted reply is compared
// field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module csr_lookup_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [celu_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [celu_pkg::OP_W-1:0]       in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [celu_pkg::DATA_W-1:0]     out_tdata,
  input  logic [celu_pkg::STAT_W-1:0]     out_tuser,
  output int                              bad_fields,
  output int                              replies_owed
);

  typedef struct packed {
    logic [celu_pkg::DATA_W-1:0] read_word;
    celu_pkg::status_t           status;
  } csr_reply_t;

  // private copy of the store
  logic [celu_pkg::LEN_W-1:0]  row_len_tbl   [celu_pkg::MAX_ROWS_DEF];
  logic [12:0]                 row_start_tbl [celu_pkg::MAX_ROWS_DEF];
  logic [celu_pkg::COL_W-1:0]  col_tbl       [celu_pkg::MAX_ENTRIES_DEF];
  logic [celu_pkg::DATA_W-1:0] value_tbl     [celu_pkg::MAX_ENTRIES_DEF];
  logic [8:0]                  rows_in;
  logic [12:0]                 entries_in;
  logic [12:0]                 total_len;

  csr_reply_t replies_due [$];

  // One command against the store; updates the copy and returns its reply.
  function automatic csr_reply_t csr_store_access(celu_pkg::opcode_t op,
                                                  logic [celu_pkg::ROW_W-1:0] row,
                                                  logic [celu_pkg::COL_W-1:0] col,
                                                  logic [celu_pkg::LEN_W-1:0] len,
                                                  logic [celu_pkg::DATA_W-1:0] data);
    csr_reply_t rep;
    int k;
    int idx;
    int hit;
    rep.read_word = '0;
    rep.status    = celu_pkg::ST_OK;
    hit           = -1;
    case (op)
      celu_pkg::OP_LOAD: begin
        if (rows_in >= celu_pkg::MAX_ROWS_DEF ||
            int'(total_len) + int'(len) > celu_pkg::MAX_ENTRIES_DEF) begin
          rep.status = celu_pkg::ST_RANGE;
        end else begin
          row_len_tbl[rows_in[celu_pkg::ROW_W-1:0]]   = len;
          row_start_tbl[rows_in[celu_pkg::ROW_W-1:0]] = total_len;
          total_len = total_len + len;
          rows_in   = rows_in + 1'b1;
        end
      end
      celu_pkg::OP_APPEND: begin
        if (entries_in >= celu_pkg::MAX_ENTRIES_DEF) begin
          rep.status = celu_pkg::ST_RANGE;
        end else begin
          col_tbl[entries_in[11:0]] = col;
          entries_in = entries_in + 1'b1;
        end
      end
      default: begin
        if (row >= rows_in) begin
          rep.status = celu_pkg::ST_RANGE;
        end else begin
          // scan stops at the first match, the row end or the last appended column
          for (k = 0; k < int'(row_len_tbl[row]); k++) begin
            idx = int'(row_start_tbl[row]) + k;
            if (idx >= int'(entries_in)) break;
            if (col_tbl[idx] == col) begin
              hit = idx;
              break;
            end
          end
          if (hit < 0) rep.status = celu_pkg::ST_MISS;
          else if (op == celu_pkg::OP_READ) rep.read_word = value_tbl[hit];
          else value_tbl[hit] = data;
        end
      end
    endcase
    return rep;
  endfunction

  task automatic flag_field(string what, logic [celu_pkg::DATA_W-1:0] want,
                            logic [celu_pkg::DATA_W-1:0] got);
    bad_fields++;
    if (bad_fields <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    csr_reply_t due;
    int k;
    if (!rst_n) begin
      rows_in    = '0;
      entries_in = '0;
      total_len  = '0;
      for (k = 0; k < celu_pkg::MAX_ENTRIES_DEF; k++) value_tbl[k] = '0;
      replies_due.delete();
    end else begin
      // reply first: no reply can belong to a command taken at this same edge
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          flag_field("reply with none pending", '0, out_tdata);
        end else begin
          due = replies_due.pop_front();
          if (due.read_word !== out_tdata) flag_field("read_word", due.read_word, out_tdata);
          if (due.status !== celu_pkg::status_t'(out_tuser))
            flag_field("status", celu_pkg::DATA_W'(due.status),
                       celu_pkg::DATA_W'(out_tuser));
        end
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(csr_store_access(
          celu_pkg::opcode_t'(in_tuser),
          in_tdata[celu_pkg::IN_ROW_LSB +: celu_pkg::ROW_W],
          in_tdata[celu_pkg::IN_COL_LSB +: celu_pkg::COL_W],
          in_tdata[celu_pkg::IN_LEN_LSB +: celu_pkg::LEN_W],
          in_tdata[celu_pkg::IN_DATA_LSB +: celu_pkg::DATA_W]));
    end
    replies_owed = replies_due.size();
  end

endmodule

### tb/tb_csr_element_lookup_store_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csr_element_lookup_store_unit: stimulus and verdict for the CSR store
// Directed corners first (empty store, empty rows, duplicate columns, rows
// with columns still missing, odd row lengths), then mostly well-formed row
// builds (load, append its columns, hit/miss accesses) mixed with noise, under
// three idle patterns. The run closes by filling the row table and claiming
// the whole entry space. All checking lives in csr_lookup_checker.
// ----------------------------------------------------------------------------
module tb_csr_element_lookup_store_unit;

  // No transaction on either channel for this long means a hang. Worst honest
  // gap: a scan of a 511-long row plus a long run of receiver stalls.
  localparam int STALL_LIMIT = 5000;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  // [7:0] row, [15:8] column, [24:16] row_length, [88:25] data_word, [95:89] zero
  logic [celu_pkg::IN_TDATA_W-1:0] in_tdata   = '0;
  logic [celu_pkg::OP_W-1:0]       in_tuser   = celu_pkg::OP_LOAD;  // [1:0] opcode
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [celu_pkg::DATA_W-1:0]     out_tdata;  // [63:0] read_word
  logic [celu_pkg::STAT_W-1:0]     out_tuser;  // [1:0] status

  int bad_fields;
  int replies_owed;
  int quiet_cycles = 0;

  // idle odds, percent per cycle
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;

  // Shadow of what has been built, only to aim accesses at stored columns.
  int unsigned                sent_count = 0;
  int unsigned                rows_made  = 0;
  int unsigned                len_total  = 0;
  int unsigned                cols_made  = 0;
  int unsigned                row_base    [celu_pkg::MAX_ROWS_DEF];
  int unsigned                row_entries [celu_pkg::MAX_ROWS_DEF];
  logic [celu_pkg::COL_W-1:0] col_log     [celu_pkg::MAX_ENTRIES_DEF];

  csr_element_lookup_store_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  csr_lookup_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .bad_fields   (bad_fields),
    .replies_owed (replies_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= (out_idle_pct == 0) || ($urandom_range(99) >= out_idle_pct);
  end

  // hang watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [celu_pkg::DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One transaction. Starts at the next falling edge, returns right after the
  // accepting rising edge with in_tvalid still high, so back-to-back items
  // never lower it in between, except when an idle draw drops it.
  task automatic send_item(celu_pkg::opcode_t op, logic [celu_pkg::ROW_W-1:0] row,
                           logic [celu_pkg::COL_W-1:0] col,
                           logic [celu_pkg::LEN_W-1:0] len,
                           logic [celu_pkg::DATA_W-1:0] data);
    logic [celu_pkg::IN_TDATA_W-1:0] word;
    word = '0;
    word[celu_pkg::IN_ROW_LSB  +: celu_pkg::ROW_W]  = row;
    word[celu_pkg::IN_COL_LSB  +: celu_pkg::COL_W]  = col;
    word[celu_pkg::IN_LEN_LSB  +: celu_pkg::LEN_W]  = len;
    word[celu_pkg::IN_DATA_LSB +: celu_pkg::DATA_W] = data;
    @(negedge clk);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sent_count++;
    // keep the shadow in step with what the store actually took
    case (op)
      celu_pkg::OP_LOAD: begin
        if (rows_made < celu_pkg::MAX_ROWS_DEF &&
            len_total + len <= celu_pkg::MAX_ENTRIES_DEF) begin
          row_base[rows_made]    = len_total;
          row_entries[rows_made] = len;
          len_total += len;
          rows_made++;
        end
      end
      celu_pkg::OP_APPEND: begin
        if (cols_made < celu_pkg::MAX_ENTRIES_DEF) begin
          col_log[cols_made] = col;
          cols_made++;
        end
      end
      default: ;
    endcase
  endtask

  // fields a command ignores still get random values
  task automatic send_load(int unsigned len);
    send_item(celu_pkg::OP_LOAD, celu_pkg::ROW_W'($urandom), celu_pkg::COL_W'($urandom),
              celu_pkg::LEN_W'(len), rand64());
  endtask

  task automatic send_append(logic [celu_pkg::COL_W-1:0] col);
    send_item(celu_pkg::OP_APPEND, celu_pkg::ROW_W'($urandom), col,
              celu_pkg::LEN_W'($urandom), rand64());
  endtask

  task automatic send_access(celu_pkg::opcode_t op, logic [celu_pkg::ROW_W-1:0] row,
                             logic [celu_pkg::COL_W-1:0] col,
                             logic [celu_pkg::DATA_W-1:0] data);
    send_item(op, row, col, celu_pkg::LEN_W'($urandom), data);
  endtask

  // Drop valid and hold the sender until every reply is back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  // Mostly a column that is really stored in the row, else anything.
  function automatic logic [celu_pkg::COL_W-1:0] pick_col(int unsigned r);
    int unsigned avail;
    avail = 0;
    if (r < rows_made && cols_made > row_base[r]) begin
      avail = cols_made - row_base[r];
      if (avail > row_entries[r]) avail = row_entries[r];
    end
    if (avail != 0 && $urandom_range(3) != 0)
      return col_log[row_base[r] + $urandom_range(avail - 1)];
    return celu_pkg::COL_W'($urandom);
  endfunction

  task automatic random_access();
    int unsigned r;
    logic [celu_pkg::DATA_W-1:0] data;
    celu_pkg::opcode_t op;
    // mostly loaded rows, now and then any row at all
    if (rows_made != 0 && $urandom_range(9) != 0) r = $urandom_range(rows_made - 1);
    else r = $urandom_range(255);
    op = ($urandom_range(99) < 55) ? celu_pkg::OP_READ : celu_pkg::OP_WRITE;
    case ($urandom_range(7))
      0:       data = '0;
      1:       data = '1;
      default: data = rand64();
    endcase
    send_access(op, celu_pkg::ROW_W'(r), pick_col(r), data);
  endtask

  task automatic directed_checks();
    send_access(celu_pkg::OP_READ, 8'd0, 8'd0, '0);      // nothing loaded yet: range
    send_access(celu_pkg::OP_WRITE, 8'd255, 8'd255, '1); // same, extreme fields
    send_load(0);                                        // row 0 is empty
    send_load(3);                                        // row 1
    send_load(2);                                        // row 2
    send_append(8'd7);                                   // row 1: 7, 7, 255
    send_append(8'd7);
    send_append(8'd255);
    send_append(8'd0);                                   // row 2 gets only one column now
    send_access(celu_pkg::OP_READ, 8'd0, 8'd0, '0);      // empty row: miss
    send_access(celu_pkg::OP_READ, 8'd1, 8'd7, '0);      // fresh slot reads zero
    send_access(celu_pkg::OP_WRITE, 8'd1, 8'd7, '1);     // lands on the first duplicate
    send_access(celu_pkg::OP_READ, 8'd1, 8'd7, '0);
    send_access(celu_pkg::OP_WRITE, 8'd1, 8'd255, 64'h8000_0000_0000_0001);
    send_access(celu_pkg::OP_READ, 8'd1, 8'd255, '0);
    send_access(celu_pkg::OP_READ, 8'd2, 8'd0, '0);
    send_access(celu_pkg::OP_READ, 8'd2, 8'd9, '0);      // scan runs out of columns
    send_access(celu_pkg::OP_WRITE, 8'd2, 8'd9, rand64()); // miss must not write
    send_access(celu_pkg::OP_READ, 8'd3, 8'd0, '0);      // row not loaded: range
    send_load(511);                                      // row 3, largest length field
    send_load(256);                                      // row 4
    send_append(8'd0);                                   // completes row 2
    send_access(celu_pkg::OP_READ, 8'd2, 8'd0, '0);
    send_access(celu_pkg::OP_READ, 8'd3, 8'd0, '0);      // row 3 has no columns yet: miss
  endtask

  // Well-formed row builds with random content, plus loose accesses and noise.
  task automatic random_phase(int unsigned n);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    int unsigned j;
    logic [celu_pkg::COL_W-1:0] prev;
    goal = sent_count + n;
    while (sent_count < goal) begin
      pick = $urandom_range(99);
      if (pick < 70 && rows_made < 200) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(32) : $urandom_range(8);
        send_load(len);
        prev = celu_pkg::COL_W'($urandom);
        for (j = 0; j < len; j++) begin
          if ($urandom_range(19) == 0) break;       // row left short, later rows shift
          if ($urandom_range(4) != 0) prev = celu_pkg::COL_W'($urandom);  // else duplicate
          send_append(prev);
        end
        repeat ($urandom_range(2, 6)) random_access();
      end else if (pick < 88) begin
        random_access();
      end else begin
        case ($urandom_range(2))
          0:       send_load($urandom_range(3));
          1:       send_append(celu_pkg::COL_W'($urandom));
          default: send_item(celu_pkg::opcode_t'(celu_pkg::OP_W'($urandom_range(3))),
                             celu_pkg::ROW_W'($urandom), celu_pkg::COL_W'($urandom),
                             celu_pkg::LEN_W'($urandom), rand64());
        endcase
      end
    end
  endtask

  // Push the row table to its limit, claim the whole entry space, and poke at
  // the full store.
  task automatic capacity_fill();
    while (rows_made < celu_pkg::MAX_ROWS_DEF - 1 &&
           len_total + 256 <= celu_pkg::MAX_ENTRIES_DEF) send_load(256);
    send_load(256);                                 // would overrun the entry space
    if (celu_pkg::MAX_ENTRIES_DEF - len_total < 512)
      send_load(celu_pkg::MAX_ENTRIES_DEF - len_total);  // exact fit
    send_load(1);                                   // entry space fully claimed
    while (rows_made < celu_pkg::MAX_ROWS_DEF) send_load(0);
    send_load(0);                                   // row table full
    repeat (24) send_append(celu_pkg::COL_W'($urandom));
    repeat (12) random_access();
    send_access(celu_pkg::OP_READ, 8'd255, 8'd255, '0);  // last row is empty
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 10;
    out_idle_pct = 45;
    directed_checks();
    wait_drained();
    random_phase(420);
    wait_drained();

    in_idle_pct  = 45;
    out_idle_pct = 10;
    random_phase(420);
    wait_drained();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_phase(420);
    capacity_fill();
    wait_drained();

    repeat (16) @(negedge clk);
    if (bad_fields == 0 && replies_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
